/* sv/tog_pkg.sv */
// ----------------------------------------------------------------------------
// Text overlay glyph renderer package
// Shared constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tog_pkg;

    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_COUNT  = 256;
    localparam int MARGIN       = 16;

    localparam int MEM_DEPTH  = 4096;
    localparam int ADDR_W     = 12;
    localparam int POS_W      = 14;
    localparam int POS_MAX    = 16383;
    localparam int COL_W      = 11;
    localparam int ROW_W      = $clog2(GLYPH_HEIGHT);
    localparam int LEN_W      = 4;
    localparam int LEVEL_W    = 16;
    localparam int CODE_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DIM_W      = 14;
    localparam int BITS_W     = 5;
    localparam int SHIFT_W    = 2;
    localparam int DEPTH_SH_W = 4;
    localparam int CALC_W     = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_SX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_SY    = 3'd5;

    localparam logic [CODE_W-1:0] CHAR_CR         = 8'h0D;
    localparam logic [CODE_W-1:0] CHAR_LF         = 8'h0A;
    localparam logic [CODE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam int                FIRST_PRINTABLE = 32;

    localparam int INK_BASE   = 235;
    localparam int PAPER_BASE = 16;
    localparam int FILL_BASE  = 128;
    localparam int MIN_BITS   = 8;
    localparam int MAX_BITS   = 16;
    localparam int MAX_SHIFT  = 2;

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 14'd1920;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 14'd1080;
    localparam logic [BITS_W-1:0]  RST_SAMPLE_BITS  = 5'd8;
    localparam logic [SHIFT_W-1:0] RST_CHROMA_SHIFT = 2'd1;

    typedef struct packed {
        logic mem_wr;
        logic restart;
        logic newline;
        logic capture;
        logic layout;
        logic stop;
        logic begin_rows;
        logic emit_luma;
        logic emit_chroma;
        logic last;
        logic advance_col;
    } t_dp_cmd;

    typedef struct packed {
        logic stopped;
        logic is_cr;
        logic is_lf;
        logic stop_now;
        logic slot_free;
        logic luma_last;
        logic chroma_last;
        logic rgb;
    } t_dp_status;

endpackage

/* sv/tog_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tog_ctrl.sv */
// ----------------------------------------------------------------------------
// Text overlay controller
// Sequences command decode, layout, the bottom test and row emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tog_ctrl
    import tog_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_status       i_status,
    output t_dp_cmd          o_cmd,
    output logic             o_in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAYOUT,
        S_CHECK,
        S_LUMA,
        S_CHROMA
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_ready;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_LOAD:  n_cmd.mem_wr  = 1'b1;
                        CMD_START: n_cmd.restart = 1'b1;
                        CMD_CHAR: begin
                            if (!i_status.stopped) begin
                                if (i_status.is_lf) begin
                                    n_cmd.newline = 1'b1;
                                end else if (!i_status.is_cr) begin
                                    n_cmd.capture = 1'b1;
                                    n_state       = S_LAYOUT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LAYOUT: begin
                n_cmd.layout = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.stop_now) begin
                    n_cmd.stop = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cmd.begin_rows = 1'b1;
                    n_state          = S_LUMA;
                end
            end
            S_LUMA: begin
                if (i_status.slot_free) begin
                    n_cmd.emit_luma = 1'b1;
                    if (i_status.luma_last) begin
                        if (i_status.rgb) begin
                            n_cmd.last        = 1'b1;
                            n_cmd.advance_col = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            n_state = S_CHROMA;
                        end
                    end
                end
            end
            S_CHROMA: begin
                if (i_status.slot_free) begin
                    n_cmd.emit_chroma = 1'b1;
                    if (i_status.chroma_last) begin
                        n_cmd.last        = 1'b1;
                        n_cmd.advance_col = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_cmd      = (i_in_valid && r_in_ready) || (r_state != S_IDLE) ? n_cmd : '0;
    assign o_in_ready = r_in_ready;

endmodule

/* sv/tog_dp.sv */
// ----------------------------------------------------------------------------
// Text overlay datapath
// Configuration, cursor, glyph memory, row generation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tog_dp
    import tog_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_glyph_address,
    input  logic [BYTE_W-1:0]     i_glyph_byte,
    input  logic [CODE_W-1:0]     i_char_code,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_span_kind,
    output logic [POS_W-1:0]      o_pos_x,
    output logic [POS_W-1:0]      o_pos_y,
    output logic [BYTE_W-1:0]     o_glyph_bits,
    output logic [LEN_W-1:0]      o_span_length,
    output logic [LEVEL_W-1:0]    o_ink_level,
    output logic [LEVEL_W-1:0]    o_paper_level,
    output logic                  o_last
);

    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [BITS_W-1:0]  r_sample_bits;
    logic               r_rgb_mode;
    logic [SHIFT_W-1:0] r_chroma_sx;
    logic [SHIFT_W-1:0] r_chroma_sy;

    logic [COL_W-1:0]  r_col;
    logic [POS_W-1:0]  r_line_top;
    logic              r_stopped;
    logic [CODE_W-1:0] r_code;
    logic [POS_W-1:0]  r_dest_x;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;

    logic               r_out_valid;
    logic               r_span_kind;
    logic [POS_W-1:0]   r_pos_x;
    logic [POS_W-1:0]   r_pos_y;
    logic [BYTE_W-1:0]  r_glyph_bits;
    logic [LEN_W-1:0]   r_span_length;
    logic [LEVEL_W-1:0] r_ink_level;
    logic [LEVEL_W-1:0] r_paper_level;
    logic               r_last;

    logic [ADDR_W-1:0]     rd_addr;
    logic [BYTE_W-1:0]     rd_data;
    logic signed [CALC_W-1:0] s_x;
    logic signed [CALC_W-1:0] s_xlim;
    logic signed [CALC_W-1:0] s_y;
    logic signed [CALC_W-1:0] s_ylim;
    logic                  wrap;
    logic [POS_W:0]        line_sum;
    logic [POS_W-1:0]      line_next;
    logic [CODE_W-1:0]     code_drawn;
    logic [DEPTH_SH_W-1:0] depth_sh;
    logic [SHIFT_W-1:0]    sx;
    logic [SHIFT_W-1:0]    sy;
    logic [ROW_W:0]        sub_h;
    logic [LEN_W-1:0]      sub_w;
    logic [LEVEL_W-1:0]    ink;
    logic [LEVEL_W-1:0]    paper;
    logic [LEVEL_W-1:0]    fill;
    logic                  slot_free;
    logic                  luma_last;
    logic                  chroma_last;

    always_comb begin
        s_x    = CALC_W'(r_col) * CALC_W'(GLYPH_WIDTH) + CALC_W'(MARGIN);
        s_xlim = signed'(CALC_W'(r_frame_width)) - CALC_W'(GLYPH_WIDTH + MARGIN);
        wrap   = (s_x >= s_xlim);
        s_y    = signed'(CALC_W'(r_line_top));
        s_ylim = signed'(CALC_W'(r_frame_height)) - CALC_W'(GLYPH_HEIGHT);

        line_sum  = {1'b0, r_line_top} + (POS_W+1)'(GLYPH_HEIGHT);
        line_next = (line_sum > (POS_W+1)'(POS_MAX)) ? POS_W'(POS_MAX) : line_sum[POS_W-1:0];

        if ((32'(i_char_code) < FIRST_PRINTABLE) || (32'(i_char_code) >= GLYPH_COUNT)) begin
            code_drawn = CHAR_UNDERSCORE;
        end else begin
            code_drawn = i_char_code;
        end

        if (r_sample_bits < BITS_W'(MIN_BITS)) begin
            depth_sh = '0;
        end else if (r_sample_bits > BITS_W'(MAX_BITS)) begin
            depth_sh = DEPTH_SH_W'(MAX_BITS - MIN_BITS);
        end else begin
            depth_sh = DEPTH_SH_W'(r_sample_bits - BITS_W'(MIN_BITS));
        end
        ink   = LEVEL_W'(INK_BASE) << depth_sh;
        paper = LEVEL_W'(PAPER_BASE) << depth_sh;
        fill  = LEVEL_W'(FILL_BASE) << depth_sh;

        sx    = (r_chroma_sx > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : r_chroma_sx;
        sy    = (r_chroma_sy > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : r_chroma_sy;
        sub_w = LEN_W'(GLYPH_WIDTH) >> sx;
        sub_h = (ROW_W+1)'(GLYPH_HEIGHT) >> sy;

        slot_free   = !r_out_valid || i_out_ready;
        luma_last   = (r_row == ROW_W'(GLYPH_HEIGHT - 1));
        chroma_last = (r_row == ROW_W'(sub_h - 1'b1));

        if (i_cmd.begin_rows) begin
            n_row = '0;
        end else if (i_cmd.emit_luma) begin
            n_row = luma_last ? '0 : r_row + 1'b1;
        end else if (i_cmd.emit_chroma) begin
            n_row = r_row + 1'b1;
        end else begin
            n_row = r_row;
        end

        rd_addr = ADDR_W'(32'(r_code) * GLYPH_HEIGHT + 32'(n_row));
    end

    tog_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_waddr (i_glyph_address),
        .i_wdata (i_glyph_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_sample_bits  <= RST_SAMPLE_BITS;
            r_rgb_mode     <= 1'b0;
            r_chroma_sx    <= RST_CHROMA_SHIFT;
            r_chroma_sy    <= RST_CHROMA_SHIFT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_SAMPLE_BITS:  r_sample_bits  <= i_cfg_data[BITS_W-1:0];
                CFG_RGB_MODE:     r_rgb_mode     <= i_cfg_data[0];
                CFG_CHROMA_SX:    r_chroma_sx    <= i_cfg_data[SHIFT_W-1:0];
                CFG_CHROMA_SY:    r_chroma_sy    <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_line_top  <= POS_W'(MARGIN);
            r_stopped   <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row <= n_row;
            if (i_cmd.restart) begin
                r_col      <= '0;
                r_line_top <= POS_W'(MARGIN);
                r_stopped  <= 1'b0;
            end
            if (i_cmd.newline || (i_cmd.layout && wrap)) begin
                r_col      <= '0;
                r_line_top <= line_next;
            end
            if (i_cmd.stop) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.advance_col) begin
                r_col <= r_col + 1'b1;
            end
            if (i_cmd.emit_luma || i_cmd.emit_chroma) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code <= code_drawn;
        end
        if (i_cmd.layout) begin
            r_dest_x <= wrap ? POS_W'(MARGIN) : s_x[POS_W-1:0];
        end
        if (i_cmd.emit_luma) begin
            r_span_kind   <= 1'b0;
            r_pos_x       <= r_dest_x;
            r_pos_y       <= r_line_top + POS_W'(r_row);
            r_glyph_bits  <= rd_data;
            r_span_length <= LEN_W'(GLYPH_WIDTH);
            r_ink_level   <= ink;
            r_paper_level <= paper;
            r_last        <= i_cmd.last;
        end else if (i_cmd.emit_chroma) begin
            r_span_kind   <= 1'b1;
            r_pos_x       <= r_dest_x >> sx;
            r_pos_y       <= (r_line_top >> sy) + POS_W'(r_row);
            r_glyph_bits  <= '0;
            r_span_length <= sub_w;
            r_ink_level   <= fill;
            r_paper_level <= fill;
            r_last        <= i_cmd.last;
        end
    end

    always_comb begin
        o_status.stopped     = r_stopped;
        o_status.is_cr       = (i_char_code == CHAR_CR);
        o_status.is_lf       = (i_char_code == CHAR_LF);
        o_status.stop_now    = (s_y >= s_ylim);
        o_status.slot_free   = slot_free;
        o_status.luma_last   = luma_last;
        o_status.chroma_last = chroma_last;
        o_status.rgb         = r_rgb_mode;
    end

    assign o_out_valid   = r_out_valid;
    assign o_span_kind   = r_span_kind;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_glyph_bits  = r_glyph_bits;
    assign o_span_length = r_span_length;
    assign o_ink_level   = r_ink_level;
    assign o_paper_level = r_paper_level;
    assign o_last        = r_last;

endmodule

/* sv/text_overlay_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// Text overlay glyph renderer
// On-screen 8x16 character generator with a loadable glyph memory.
// ----------------------------------------------------------------------------
// Glyph loads, start-of-text commands, carriage returns, newlines and text
// that arrives after drawing has stopped are handled in the idle state. A
// drawn character passes through decode, wrap test and bottom test and then,
// unless the bottom test stops drawing, emits one output row per cycle while
// the output register is free: sixteen glyph rows, plus 16 >> min(chroma_shift_y, 2)
// chroma fill rows in YUV mode. The row rate is set by the single output
// register and the one read port of the glyph memory, read one row ahead.
`timescale 1ns / 1ps

module text_overlay_glyph_renderer
    import tog_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [ADDR_W-1:0]     i_glyph_address,
    input  logic [BYTE_W-1:0]     i_glyph_byte,
    input  logic [CODE_W-1:0]     i_char_code,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_span_kind,
    output logic [POS_W-1:0]      o_pos_x,
    output logic [POS_W-1:0]      o_pos_y,
    output logic [BYTE_W-1:0]     o_glyph_bits,
    output logic [LEN_W-1:0]      o_span_length,
    output logic [LEVEL_W-1:0]    o_ink_level,
    output logic [LEVEL_W-1:0]    o_paper_level,
    output logic                  o_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tog_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_ready (o_in_ready)
    );

    tog_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_glyph_address (i_glyph_address),
        .i_glyph_byte    (i_glyph_byte),
        .i_char_code     (i_char_code),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_span_kind     (o_span_kind),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_glyph_bits    (o_glyph_bits),
        .o_span_length   (o_span_length),
        .o_ink_level     (o_ink_level),
        .o_paper_level   (o_paper_level),
        .o_last          (o_last)
    );

endmodule

/* sv/tog_checker.sv */
// ----------------------------------------------------------------------------
// Text overlay port checker
// Watches the top-level ports for output hold, reset and row format rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tog_checker
    import tog_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_span_kind,
    input logic [POS_W-1:0]      o_pos_x,
    input logic [POS_W-1:0]      o_pos_y,
    input logic [BYTE_W-1:0]     o_glyph_bits,
    input logic [LEN_W-1:0]      o_span_length,
    input logic [LEVEL_W-1:0]    o_ink_level,
    input logic [LEVEL_W-1:0]    o_paper_level,
    input logic                  o_last
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid not cleared by reset");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_glyph_bits) && $stable(o_last)))
        else $error("stalled output row changed");

    a_glyph_row_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_span_kind) |-> (o_span_length == LEN_W'(GLYPH_WIDTH)))
        else $error("glyph row has wrong length");

    a_fill_row_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_span_kind) |-> (o_ink_level == o_paper_level
            && o_glyph_bits == '0))
        else $error("chroma fill row is not flat");

endmodule

bind text_overlay_glyph_renderer tog_checker u_tog_checker (.*);

/* tb/tb_text_overlay_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// Text overlay glyph renderer testbench
// Self-checking regression for the 8x16 character generator. A behavioral
// predictor tracks glyph memory, cursor, line position and the stop state,
// and expands every drawn character into its glyph and chroma fill spans.
// Directed tests cover defaults, sample depths, plane modes, wrapping,
// stopping at the frame edges and one long output stall. Random phases then
// run with varied settings and idle bursts on both sides, except the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_overlay_glyph_renderer;
    import tog_pkg::*;

    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          DRAIN_CYCLES = 48;
    localparam int          GLYPH_SET_MAX = 10;
    localparam int          PHASE_ITEMS  = 36;
    localparam logic        SPAN_GLYPH   = 1'b0;
    localparam logic        SPAN_FILL    = 1'b1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic                kind;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [BYTE_W-1:0]   bits;
        logic [LEN_W-1:0]    len;
        logic [LEVEL_W-1:0]  ink;
        logic [LEVEL_W-1:0]  paper;
        logic                last;
    } t_span;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command = CMD_LOAD;
    logic [ADDR_W-1:0]     i_glyph_address = '0;
    logic [BYTE_W-1:0]     i_glyph_byte = '0;
    logic [CODE_W-1:0]     i_char_code = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_span_kind;
    logic [POS_W-1:0]      o_pos_x;
    logic [POS_W-1:0]      o_pos_y;
    logic [BYTE_W-1:0]     o_glyph_bits;
    logic [LEN_W-1:0]      o_span_length;
    logic [LEVEL_W-1:0]    o_ink_level;
    logic [LEVEL_W-1:0]    o_paper_level;
    logic                  o_last;

    text_overlay_glyph_renderer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_glyph_address(i_glyph_address),
        .i_glyph_byte   (i_glyph_byte),
        .i_char_code    (i_char_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_span_kind    (o_span_kind),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_glyph_bits   (o_glyph_bits),
        .o_span_length  (o_span_length),
        .o_ink_level    (o_ink_level),
        .o_paper_level  (o_paper_level),
        .o_last         (o_last)
    );

    // Predictor state and register copies.
    logic [BYTE_W-1:0]  glyph_mem [MEM_DEPTH];
    bit                 glyph_written [MEM_DEPTH];
    bit                 code_ready [GLYPH_COUNT];
    logic [CODE_W-1:0]  ready_codes [$];
    logic [COL_W-1:0]   col_pos;
    int                 line_y;
    bit                 drawing_halted;
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [BITS_W-1:0]  cfg_bits;
    logic               cfg_rgb;
    logic [SHIFT_W-1:0] cfg_sx;
    logic [SHIFT_W-1:0] cfg_sy;

    t_span pending_spans [$];
    bit    item_acted;
    bit    src_idle_en = 1'b0;
    bit    sink_idle_en = 1'b0;
    int    hold_request = 0;
    int    cycle_count = 0;
    int    mismatch_count = 0;
    int    spans_checked = 0;
    int    items_sent = 0;
    int    chars_drawn = 0;
    int    line_wraps = 0;
    int    text_stops = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d spans pending", cycle_count,
                     pending_spans.size());
            $display("text_overlay_glyph_renderer regression: fail");
            $finish;
        end
    end

    function automatic logic [CODE_W-1:0] drawn_code(input logic [CODE_W-1:0] code);
        return (code < FIRST_PRINTABLE) ? CHAR_UNDERSCORE : code;
    endfunction

    function automatic void next_line();
        line_y = (line_y + GLYPH_HEIGHT > POS_MAX) ? POS_MAX : line_y + GLYPH_HEIGHT;
        col_pos = '0;
    endfunction

    task automatic reset_predictor();
        for (int a = 0; a < MEM_DEPTH; a++) begin
            glyph_written[a] = 1'b0;
            glyph_mem[a] = '0;
        end
        col_pos = '0;
        line_y = MARGIN;
        drawing_halted = 1'b0;
        cfg_width = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cfg_bits = RST_SAMPLE_BITS;
        cfg_rgb = 1'b0;
        cfg_sx = RST_CHROMA_SHIFT;
        cfg_sy = RST_CHROMA_SHIFT;
    endtask

    task automatic predict_spans(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [BYTE_W-1:0] gbyte,
                                 input logic [CODE_W-1:0] code);
        int                 dx;
        int                 dy;
        int                 depth;
        int                 sx;
        int                 sy;
        int                 total;
        int                 r;
        logic [CODE_W-1:0]  g;
        logic [LEVEL_W-1:0] ink;
        logic [LEVEL_W-1:0] paper;
        logic [LEVEL_W-1:0] fill;
        t_span              s;
        item_acted = 1'b1;
        if (cmd == CMD_LOAD) begin
            glyph_mem[addr] = gbyte;
            glyph_written[addr] = 1'b1;
        end else if (cmd == CMD_START) begin
            col_pos = '0;
            line_y = MARGIN;
            drawing_halted = 1'b0;
        end else if (cmd != CMD_CHAR || drawing_halted || code == CHAR_CR) begin
            item_acted = 1'b0;
        end else if (code == CHAR_LF) begin
            next_line();
        end else begin
            dx = MARGIN + int'(col_pos) * GLYPH_WIDTH;
            if (dx >= int'(cfg_width) - GLYPH_WIDTH - MARGIN) begin
                next_line();
                dx = MARGIN;
                line_wraps++;
            end
            dy = line_y;
            if (dy >= int'(cfg_height) - GLYPH_HEIGHT) begin
                drawing_halted = 1'b1;
                text_stops++;
            end else begin
                g = drawn_code(code);
                depth = (cfg_bits < MIN_BITS) ? MIN_BITS :
                        ((cfg_bits > MAX_BITS) ? MAX_BITS : int'(cfg_bits));
                ink = LEVEL_W'(INK_BASE << (depth - MIN_BITS));
                paper = LEVEL_W'(PAPER_BASE << (depth - MIN_BITS));
                fill = LEVEL_W'(FILL_BASE << (depth - MIN_BITS));
                sx = (cfg_sx > MAX_SHIFT) ? MAX_SHIFT : int'(cfg_sx);
                sy = (cfg_sy > MAX_SHIFT) ? MAX_SHIFT : int'(cfg_sy);
                total = GLYPH_HEIGHT + (cfg_rgb ? 0 : (GLYPH_HEIGHT >> sy));
                for (r = 0; r < total; r++) begin
                    if (r < GLYPH_HEIGHT) begin
                        s.kind = SPAN_GLYPH;
                        s.x = POS_W'(dx);
                        s.y = POS_W'(dy + r);
                        s.bits = glyph_mem[{g, ROW_W'(r)}];
                        s.len = LEN_W'(GLYPH_WIDTH);
                        s.ink = ink;
                        s.paper = paper;
                    end else begin
                        s.kind = SPAN_FILL;
                        s.x = POS_W'(dx >> sx);
                        s.y = POS_W'((dy >> sy) + r - GLYPH_HEIGHT);
                        s.bits = '0;
                        s.len = LEN_W'(GLYPH_WIDTH >> sx);
                        s.ink = fill;
                        s.paper = fill;
                    end
                    s.last = (r == total - 1);
                    pending_spans.push_back(s);
                end
                col_pos = col_pos + 1'b1;
                chars_drawn++;
            end
        end
    endtask

    // Called at a rising edge; returns at the edge of the transfer or after a gap.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] gbyte, input logic [CODE_W-1:0] code);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_glyph_address <= addr;
        i_glyph_byte <= gbyte;
        i_char_code <= code;
        do @(posedge i_clk); while (!o_in_ready);
        predict_spans(cmd, addr, gbyte, code);
        items_sent++;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic load_missing_glyph(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] g;
        int                r;
        g = drawn_code(code);
        for (r = 0; r < GLYPH_HEIGHT; r++) begin
            if (!glyph_written[{g, ROW_W'(r)}])
                send_item(CMD_LOAD, {g, ROW_W'(r)}, BYTE_W'($urandom), CODE_W'($urandom));
        end
        if (!code_ready[g]) begin
            code_ready[g] = 1'b1;
            ready_codes.push_back(g);
        end
    endtask

    task automatic send_char(input logic [CODE_W-1:0] code);
        load_missing_glyph(code);
        send_item(CMD_CHAR, ADDR_W'($urandom), BYTE_W'($urandom), code);
    endtask

    task automatic send_control(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code);
        send_item(cmd, ADDR_W'($urandom), BYTE_W'($urandom), code);
    endtask

    // New glyphs cost a full set of row loads, so only a small set is used.
    function automatic logic [CODE_W-1:0] pick_code();
        if (ready_codes.size() == 0 ||
            (ready_codes.size() < GLYPH_SET_MAX && $urandom_range(0, 3) == 0))
            return CODE_W'($urandom);
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width = data;
            CFG_FRAME_HEIGHT: cfg_height = data;
            CFG_SAMPLE_BITS:  cfg_bits = data[BITS_W-1:0];
            CFG_RGB_MODE:     cfg_rgb = data[0];
            CFG_CHROMA_SX:    cfg_sx = data[SHIFT_W-1:0];
            CFG_CHROMA_SY:    cfg_sy = data[SHIFT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Unused upper data bits are randomized; the block must ignore them.
    task automatic apply_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [BITS_W-1:0] bits, input logic rgb,
                                input logic [SHIFT_W-1:0] sx, input logic [SHIFT_W-1:0] sy);
        wait_for_drain();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_SAMPLE_BITS, {9'($urandom), bits});
        write_reg(CFG_RGB_MODE, {13'($urandom), rgb});
        write_reg(CFG_CHROMA_SX, {12'($urandom), sx});
        write_reg(CFG_CHROMA_SY, {12'($urandom), sy});
    endtask

    initial begin : out_ready_driver
        int hold;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [LEVEL_W-1:0] want,
                                        input logic [LEVEL_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : span_checker
        t_span want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_spans.size() == 0) begin
                mismatch_count++;
                $display("%0t: span transfer, expected none, actual kind %0d at (%0d,%0d)",
                         $time, o_span_kind, o_pos_x, o_pos_y);
            end else begin
                want = pending_spans.pop_front();
                check_field("span_kind", LEVEL_W'(want.kind), LEVEL_W'(o_span_kind));
                check_field("pos_x", LEVEL_W'(want.x), LEVEL_W'(o_pos_x));
                check_field("pos_y", LEVEL_W'(want.y), LEVEL_W'(o_pos_y));
                check_field("glyph_bits", LEVEL_W'(want.bits), LEVEL_W'(o_glyph_bits));
                check_field("span_length", LEVEL_W'(want.len), LEVEL_W'(o_span_length));
                check_field("ink_level", want.ink, o_ink_level);
                check_field("paper_level", want.paper, o_paper_level);
                check_field("last", LEVEL_W'(want.last), LEVEL_W'(o_last));
                spans_checked++;
            end
        end
    end

    task automatic test_default_drawing();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        send_item(CMD_LOAD, '0, '0, '0);
        send_item(CMD_LOAD, '1, '1, '1);
        send_control(CMD_START, CODE_W'($urandom));
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'h1F);
        send_char(8'h20);
        send_char(8'h7F);
        send_char(8'hFF);
        send_control(CMD_CHAR, CHAR_CR);
        send_control(CMD_CHAR, CHAR_LF);
        send_char(8'h80);
        send_item(CMD_UNUSED, '1, '1, '1);
        send_char(8'h42);
    endtask

    task automatic test_depth_and_planes();
        int k;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: apply_config(14'd1920, 14'd1080, 5'd16, 1'b1, 2'd0, 2'd0);
                1: apply_config(14'd1920, 14'd1080, 5'd0, 1'b0, 2'd2, 2'd2);
                2: apply_config(14'd1920, 14'd1080, 5'd31, 1'b0, 2'd0, 2'd0);
                3: apply_config(14'd1920, 14'd1080, 5'd12, 1'b0, 2'd3, 2'd3);
                default: apply_config(14'd1920, 14'd1080, 5'd9, 1'b0, 2'd1, 2'd0);
            endcase
            send_control(CMD_START, CODE_W'($urandom));
            send_char(pick_code());
            send_char(pick_code());
        end
    endtask

    task automatic test_wrap_and_stop();
        apply_config(14'd60, 14'd64, 5'd8, 1'b0, 2'd1, 2'd1);
        send_control(CMD_START, CODE_W'($urandom));
        repeat (8) send_char(pick_code());
        send_control(CMD_CHAR, CHAR_LF);
        send_control(CMD_CHAR, CHAR_CR);
        send_char(pick_code());
        send_control(CMD_START, CODE_W'($urandom));
        repeat (2) send_char(pick_code());
        apply_config(14'd0, 14'd1080, 5'd8, 1'b0, 2'd1, 2'd1);
        send_control(CMD_START, CODE_W'($urandom));
        repeat (4) send_char(pick_code());
        apply_config(14'd16383, 14'd0, 5'd8, 1'b1, 2'd1, 2'd1);
        send_control(CMD_START, CODE_W'($urandom));
        repeat (2) send_char(pick_code());
    endtask

    // Newlines step down to the last line that still fits, then one more stops.
    task automatic test_bottom_edge();
        apply_config(14'd1920, 14'd128, 5'd8, 1'b0, 2'd0, 2'd0);
        src_idle_en = 1'b0;
        send_control(CMD_START, CODE_W'($urandom));
        repeat (5) send_control(CMD_CHAR, CHAR_LF);
        repeat (2) send_char(pick_code());
        send_control(CMD_CHAR, CHAR_LF);
        send_char(pick_code());
        send_control(CMD_CHAR, CHAR_LF);
        send_char(pick_code());
        send_control(CMD_START, CODE_W'($urandom));
        send_char(pick_code());
        src_idle_en = 1'b1;
    endtask

    // The output side stalls long enough for the block to stop taking input.
    task automatic test_output_backpressure();
        apply_config(14'd1920, 14'd1080, 5'd10, 1'b0, 2'd0, 2'd0);
        send_control(CMD_START, CODE_W'($urandom));
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_request = 400;
        repeat (24) send_char(pick_code());
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_control(CMD_START, CODE_W'($urandom));
        else if (pick < 20)
            send_item(CMD_LOAD, ADDR_W'($urandom), BYTE_W'($urandom), CODE_W'($urandom));
        else if (pick < 24)
            send_item(CMD_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom), CODE_W'($urandom));
        else if (pick < 31)
            send_control(CMD_CHAR, CHAR_LF);
        else if (pick < 34)
            send_control(CMD_CHAR, CHAR_CR);
        else
            send_char(pick_code());
    endtask

    task automatic test_random_traffic();
        int               phase;
        int               acted;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        for (phase = 0; phase < 6; phase++) begin
            if ($urandom_range(0, 7) == 0)
                w = $urandom_range(0, 1) ? 14'd16383 : 14'd0;
            else
                w = DIM_W'($urandom_range(40, 800));
            if ($urandom_range(0, 7) == 0)
                h = $urandom_range(0, 1) ? 14'd16383 : 14'd0;
            else
                h = DIM_W'($urandom_range(32, 400));
            apply_config(w, h, BITS_W'($urandom_range(0, 31)), 1'($urandom),
                         SHIFT_W'($urandom), SHIFT_W'($urandom));
            src_idle_en = (phase != 5);
            sink_idle_en = (phase != 5);
            send_control(CMD_START, CODE_W'($urandom));
            acted = 0;
            while (acted < PHASE_ITEMS) begin
                send_random_item();
                if (item_acted)
                    acted++;
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_drawing();
        test_depth_and_planes();
        test_wrap_and_stop();
        test_bottom_edge();
        test_output_backpressure();
        test_random_traffic();
        wait_for_drain();
        $display("Sent %0d input transfers and checked %0d spans from %0d drawn characters.",
                 items_sent, spans_checked, chars_drawn);
        $display("Exercised %0d line wraps, %0d text stops, RGB and YUV planes, all depths.",
                 line_wraps, text_stops);
        if (mismatch_count == 0)
            $display("text_overlay_glyph_renderer regression: pass");
        else
            $display("text_overlay_glyph_renderer regression: fail");
        $finish;
    end

endmodule
